@@ hdl/fmrt_pkg.sv @@
// Shared types for the first-match record table: command codes and the cell link.
`timescale 1ns / 1ps
`default_nettype none
package fmrt_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_FIND_KEY = 3'd2,
    CMD_FIND_NUM = 3'd3,
    CMD_DELETE   = 3'd4,
    CMD_UPDATE   = 3'd5
  } cmd_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic valid;  // token present in this stage
    logic hit;    // an earlier slot already matched
  } link_t;

endpackage
`default_nettype wire

@@ hdl/fmrt_cell.sv @@
// One table slot: holds a record, tests the passing token and hands it on.
`timescale 1ns / 1ps
`default_nettype none
module fmrt_cell
  import fmrt_pkg::*;
#(
  parameter int TW = 56
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmd_t          cmd,
  input  wire logic [31:0]   cmd_key,
  input  wire logic [15:0]   cmd_num,
  input  wire logic [TW-1:0] cmd_text,
  input  wire logic [TW-1:0] upd_text,
  input  wire logic          keep,
  input  wire link_t         link_in,
  input  wire logic [31:0]   rkey_in,
  input  wire logic [15:0]   rnum_in,
  input  wire logic [TW-1:0] rtext_in,
  output link_t              link_out,
  output logic [31:0]        rkey_out,
  output logic [15:0]        rnum_out,
  output logic [TW-1:0]      rtext_out
);

  logic [31:0]   rec_key;
  logic [15:0]   rec_num;
  logic [TW-1:0] rec_text;
  logic          act;
  logic          match;
  logic          take;
  logic          is_find;

  assign act     = link_in.valid && !link_in.hit;
  assign is_find = (cmd == CMD_FIND_KEY) || (cmd == CMD_FIND_NUM);

  always_comb begin
    case (cmd)
      CMD_ADD:                              match = (rec_key == 32'd0);
      CMD_FIND_KEY, CMD_DELETE, CMD_UPDATE: match = (rec_key == cmd_key);
      CMD_FIND_NUM:                         match = (rec_num == cmd_num);
      default:                              match = 1'b0;
    endcase
  end

  assign take = act && match;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_key  <= '0;
      rec_num  <= '0;
      rec_text <= '0;
      link_out <= '0;
    end else begin
      link_out.valid <= link_in.valid;
      link_out.hit   <= link_in.hit | take;
      if (act) begin
        case (cmd)
          CMD_CLEAR: begin
            rec_key  <= '0;
            rec_num  <= '0;
            rec_text <= '0;
          end
          CMD_ADD: begin
            if (match) begin
              rec_key  <= cmd_key;
              rec_num  <= cmd_num;
              rec_text <= cmd_text;
            end
          end
          CMD_DELETE: begin
            if (match) begin
              rec_key  <= '0;
              rec_num  <= '0;
              rec_text <= '0;
            end
          end
          CMD_UPDATE: begin
            if (match) begin
              rec_num <= cmd_num;
              if (!keep) begin
                rec_text <= upd_text;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload rides with the token; no reset needed.
  always_ff @(posedge clk) begin
    if (take && is_find) begin
      rkey_out  <= rec_key;
      rnum_out  <= rec_num;
      rtext_out <= rec_text;
    end else begin
      rkey_out  <= rkey_in;
      rnum_out  <= rnum_in;
      rtext_out <= rtext_in;
    end
  end

endmodule
`default_nettype wire

@@ hdl/first_match_record_table.sv @@
// Top level of the first-match record table: command capture, cell chain, result register.
// A command beat passes one start register, then the token walks the chain of RECORDS slot
//   cells one cell per cycle, then one result register raises rsp_valid.
// One command at a time: cmd_stall stays high from acceptance until the
//   result beat is taken.
// Reset (rst, synchronous) empties every slot at once and drops any command in flight.
`timescale 1ns / 1ps
`default_nettype none
module first_match_record_table
  import fmrt_pkg::*;
#(
  parameter int RECORDS    = 64,
  parameter int TEXT_BYTES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // command channel
  input  wire logic                      cmd_valid,
  output logic                           cmd_stall,
  input  wire logic [2:0]                cmd,
  input  wire logic [31:0]               key,
  input  wire logic [15:0]               num_value,
  input  wire logic [(TEXT_BYTES-1)*8-1:0] text_bytes,
  input  wire logic                      keep_text,
  // response channel
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic                           found,
  output logic [31:0]                    out_key,
  output logic [15:0]                    out_number,
  output logic [(TEXT_BYTES-1)*8-1:0]    out_text
);

  localparam int NB = TEXT_BYTES - 1;  // stored text bytes
  localparam int TW = NB * 8;

  // Control
  logic busy;
  logic start;
  logic cmd_beat;
  logic rsp_beat;

  // Command held steady for the whole walk and broadcast to every cell
  cmd_t          cmd_q;
  logic [31:0]   key_q;
  logic [15:0]   num_q;
  logic [TW-1:0] text_q;
  logic [TW-1:0] upd_q;
  logic          keep_q;

  // Update text: bytes up to the first zero byte, zero after it
  logic [TW-1:0] upd_next;

  // Chain taps: tap 0 feeds the first slot, tap RECORDS leaves the last
  link_t         link  [RECORDS+1];
  logic [31:0]   rkey  [RECORDS+1];
  logic [15:0]   rnum  [RECORDS+1];
  logic [TW-1:0] rtext [RECORDS+1];

  assign cmd_stall = busy;
  assign cmd_beat  = cmd_valid && !busy;
  assign rsp_beat  = rsp_valid && !rsp_stall;

  always_comb begin
    logic alive;
    alive    = 1'b1;
    upd_next = '0;
    for (int b = 0; b < NB; b++) begin
      if (text_bytes[b*8 +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        upd_next[b*8 +: 8] = text_bytes[b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      start     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      start <= cmd_beat;
      if (cmd_beat) begin
        busy <= 1'b1;
      end
      // token leaves the last slot: park the result
      if (link[RECORDS].valid) begin
        rsp_valid <= 1'b1;
      end
      if (rsp_beat) begin
        rsp_valid <= 1'b0;
        busy      <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_beat) begin
      cmd_q  <= cmd_t'(cmd);
      key_q  <= key;
      num_q  <= num_value;
      text_q <= text_bytes;
      upd_q  <= upd_next;
      keep_q <= keep_text;
    end
    if (link[RECORDS].valid) begin
      found      <= link[RECORDS].hit;
      out_key    <= rkey[RECORDS];
      out_number <= rnum[RECORDS];
      out_text   <= rtext[RECORDS];
    end
  end

  // Token enters with no hit and an all-zero result
  assign link[0]  = '{valid: start, hit: 1'b0};
  assign rkey[0]  = '0;
  assign rnum[0]  = '0;
  assign rtext[0] = '0;

  for (genvar i = 0; i < RECORDS; i++) begin : g_slot
    fmrt_cell #(
      .TW(TW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd_q),
      .cmd_key  (key_q),
      .cmd_num  (num_q),
      .cmd_text (text_q),
      .upd_text (upd_q),
      .keep     (keep_q),
      .link_in  (link[i]),
      .rkey_in  (rkey[i]),
      .rnum_in  (rnum[i]),
      .rtext_in (rtext[i]),
      .link_out (link[i+1]),
      .rkey_out (rkey[i+1]),
      .rnum_out (rnum[i+1]),
      .rtext_out(rtext[i+1])
    );
  end

endmodule
`default_nettype wire

@@ hdl/fmrt_checker.sv @@
// Port-level checks for the first-match record table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fmrt_checker #(
  parameter int TEXT_BYTES = 8
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cmd_valid,
  input wire logic                        cmd_stall,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_stall,
  input wire logic                        found,
  input wire logic [31:0]                 out_key,
  input wire logic [15:0]                 out_number,
  input wire logic [(TEXT_BYTES-1)*8-1:0] out_text
);

  // one command in flight: no new beat while a result waits
  a_busy_on_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> cmd_stall)
    else $error("command taken while a result is pending");

  a_stall_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("second command taken during a walk");

  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> !rsp_valid)
    else $error("result beat before the walk could finish");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !found) |-> (out_key == 32'd0 && out_number == 16'd0 && out_text == '0))
    else $error("miss with nonzero record fields");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(found) && $stable(out_key)
                                  && $stable(out_number) && $stable(out_text)))
    else $error("stalled result beat changed");

endmodule

bind first_match_record_table fmrt_checker #(
  .TEXT_BYTES(TEXT_BYTES)
) u_fmrt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .found     (found),
  .out_key   (out_key),
  .out_number(out_number),
  .out_text  (out_text)
);
`default_nettype wire
